// ----- sv/qoi_pkg.sv -----
// Shared types, constants and the color hash for the QOI chunk decoder.
package qoi_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int SLOT_BITS     = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    // chunk tags
    localparam logic [7:0] TAG_RGB   = 8'hfe;
    localparam logic [7:0] TAG_RGBA  = 8'hff;
    localparam logic [1:0] OP_INDEX  = 2'b00;
    localparam logic [1:0] OP_DIFF   = 2'b01;
    localparam logic [1:0] OP_LUMA   = 2'b10;
    localparam logic [1:0] OP_RUN    = 2'b11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam pixel_t PIXEL_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hff};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_image;
    } byte_item_t;

    typedef struct packed {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [7:0]            alpha;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  burst_end;
        logic                  image_end;
    } pixel_item_t;

    // parser -> emitter
    typedef struct packed {
        logic clear;
        logic emit;
        logic last;
    } emit_ctl_t;

    // emitter -> parser
    typedef struct packed {
        logic ready;
        logic done;
    } emit_status_t;

    // (3r + 5g + 7b + 11a) mod 64
    function automatic logic [SLOT_BITS-1:0] slot_of(input pixel_t p);
        return SLOT_BITS'(p.red[5:0] * 6'd3 + p.green[5:0] * 6'd5
                        + p.blue[5:0] * 6'd7 + p.alpha[5:0] * 6'd11);
    endfunction

endpackage

// ----- sv/qoi_color_ram.sv -----
// 64-entry color index: synchronous RAM with per-entry valid bits.
module qoi_color_ram (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      rd_en,
    input  logic [qoi_pkg::SLOT_BITS-1:0] rd_addr,
    output qoi_pkg::pixel_t           rd_data,
    input  logic                      wr_en,
    input  logic [qoi_pkg::SLOT_BITS-1:0] wr_addr,
    input  qoi_pkg::pixel_t           wr_data
);
    import qoi_pkg::*;

    localparam int DEPTH = 1 << SLOT_BITS;

    pixel_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    pixel_t             rd_word_reg;
    logic               rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                // a clear in the same cycle wins over the old valid bit
                rd_valid_reg <= valid_reg[rd_addr] & ~clear;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : pixel_t'('0);

endmodule

// ----- sv/qoi_pixel_emitter.sv -----
// Pixel output register with column/row tracking and image-end detection.
module qoi_pixel_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qoi_pkg::emit_ctl_t            ctl,
    input  qoi_pkg::pixel_t               pixel,
    input  logic [qoi_pkg::COORD_BITS-1:0] width,
    input  logic [qoi_pkg::COORD_BITS-1:0] height,
    output qoi_pkg::emit_status_t         status,
    output logic                          pixel_valid,
    input  logic                          pixel_ready,
    output qoi_pkg::pixel_item_t          pixel_item
);
    import qoi_pkg::*;

    logic                  out_valid_reg;
    pixel_item_t           out_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic                  done_reg;

    logic                  load;
    logic [COORD_BITS:0]   col_inc;
    logic [COORD_BITS:0]   row_inc;
    logic                  wrap;
    logic                  img_end;

    assign status.ready = ~out_valid_reg | pixel_ready;
    assign status.done  = done_reg;
    assign load         = ctl.emit & status.ready & ~done_reg;

    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;
    assign wrap    = col_inc >= {1'b0, width};
    assign img_end = wrap & (row_inc >= {1'b0, height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ctl.clear)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                done_reg <= 1'b0;
            end
            else if (load)
            begin
                if (wrap)
                begin
                    col_reg  <= '0;
                    row_reg  <= img_end ? '0 : row_inc[COORD_BITS-1:0];
                    done_reg <= img_end;
                end
                else
                begin
                    col_reg <= col_inc[COORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.red       <= pixel.red;
            out_reg.green     <= pixel.green;
            out_reg.blue      <= pixel.blue;
            out_reg.alpha     <= pixel.alpha;
            out_reg.column    <= col_reg;
            out_reg.row       <= row_reg;
            out_reg.burst_end <= ctl.last | img_end;
            out_reg.image_end <= img_end;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_item  = out_reg;

endmodule

// ----- sv/qoi_image_decoder.sv -----
// Top level of the QOI chunk-stream decoder: byte parser, color index and pixel output.
//
// Usage:
//   cfg channel   : cfg_index/cfg_data write image_width (index 0) and image_height
//                   (index 1); always ready. Write only while the decoder is idle.
//   byte channel  : one chunk-stream byte per transaction (header already stripped);
//                   start_image on the first byte of an image clears the color index,
//                   current pixel, position and parse phase before that byte is parsed.
//   pixel channel : one decoded pixel per transaction with column and row; burst_end
//                   marks the last pixel of a byte, image_end the final pixel.
// Timing:
//   A byte that yields no pixel passes through accept and decode. A byte that yields
//   n pixels passes through accept with the index RAM read issued, decode,
//   index write-back at the color hash, then one pixel per cycle while the
//   receiver is ready, each pixel going out through the pixel output register.
// Reset clears the parse state, position, registers and all index valid bits.
// A stalled receiver holds the output register; the parser waits and byte_ready
// stays low until the byte's last pixel has been loaded into the output register.
module qoi_image_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qoi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [qoi_pkg::COORD_BITS-1:0]    cfg_data,
    input  logic                              byte_valid,
    output logic                              byte_ready,
    input  qoi_pkg::byte_item_t               byte_item,
    output logic                              pixel_valid,
    input  logic                              pixel_ready,
    output qoi_pkg::pixel_item_t              pixel_item
);
    import qoi_pkg::*;

    typedef enum logic [1:0] {
        S_IN,
        S_DEC,
        S_WR,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LUMA2,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_ALPHA
    } phase_t;

    state_t                state_reg;
    phase_t                phase_reg;
    logic [7:0]            luma_tag_reg;
    logic [7:0]            byte_reg;
    pixel_t                pixel_reg;
    logic [5:0]            count_reg;   // pixels still to emit, minus one
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;

    logic                  accept;
    pixel_t                index_pixel;
    emit_ctl_t             ctl;
    emit_status_t          status;
    logic [5:0]            vg;

    assign cfg_ready  = 1'b1;
    assign byte_ready = (state_reg == S_IN);
    assign accept     = byte_valid & byte_ready;
    assign vg         = luma_tag_reg[5:0];

    assign ctl.clear = accept & byte_item.start_image;
    assign ctl.emit  = (state_reg == S_EMIT) & ~status.done;
    assign ctl.last  = (count_reg == '0);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // chunk parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IN;
            phase_reg    <= PH_TAG;
            luma_tag_reg <= '0;
            byte_reg     <= '0;
            pixel_reg    <= PIXEL_RESET;
            count_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IN:
                begin
                    if (accept)
                    begin
                        byte_reg  <= byte_item.data_byte;
                        state_reg <= S_DEC;
                        if (byte_item.start_image)
                        begin
                            pixel_reg    <= PIXEL_RESET;
                            phase_reg    <= PH_TAG;
                            luma_tag_reg <= '0;
                        end
                    end
                end

                S_DEC:
                begin
                    count_reg <= '0;
                    state_reg <= S_IN;
                    if (!status.done && width_reg != '0 && height_reg != '0)
                    begin
                        case (phase_reg)
                            PH_LUMA2:
                            begin
                                pixel_reg.red   <= pixel_reg.red + {2'b0, vg}
                                                 + {4'b0, byte_reg[7:4]} + 8'd216;
                                pixel_reg.green <= pixel_reg.green + {2'b0, vg} + 8'd224;
                                pixel_reg.blue  <= pixel_reg.blue + {2'b0, vg}
                                                 + {4'b0, byte_reg[3:0]} + 8'd216;
                                phase_reg <= PH_TAG;
                                state_reg <= S_WR;
                            end
                            PH_RED:
                            begin
                                pixel_reg.red <= byte_reg;
                                phase_reg     <= PH_GREEN;
                            end
                            PH_GREEN:
                            begin
                                pixel_reg.green <= byte_reg;
                                phase_reg       <= PH_BLUE;
                            end
                            PH_BLUE:
                            begin
                                pixel_reg.blue <= byte_reg;
                                if (luma_tag_reg == TAG_RGBA)
                                begin
                                    phase_reg <= PH_ALPHA;
                                end
                                else
                                begin
                                    phase_reg <= PH_TAG;
                                    state_reg <= S_WR;
                                end
                            end
                            PH_ALPHA:
                            begin
                                pixel_reg.alpha <= byte_reg;
                                phase_reg       <= PH_TAG;
                                state_reg       <= S_WR;
                            end
                            default:
                            begin
                                // chunk tag
                                if (byte_reg == TAG_RGB || byte_reg == TAG_RGBA)
                                begin
                                    luma_tag_reg <= byte_reg;
                                    phase_reg    <= PH_RED;
                                end
                                else
                                begin
                                    case (byte_reg[7:6])
                                        OP_INDEX:
                                        begin
                                            pixel_reg <= index_pixel;
                                            state_reg <= S_WR;
                                        end
                                        OP_DIFF:
                                        begin
                                            pixel_reg.red   <= pixel_reg.red
                                                + {6'b0, byte_reg[5:4]} + 8'd254;
                                            pixel_reg.green <= pixel_reg.green
                                                + {6'b0, byte_reg[3:2]} + 8'd254;
                                            pixel_reg.blue  <= pixel_reg.blue
                                                + {6'b0, byte_reg[1:0]} + 8'd254;
                                            state_reg <= S_WR;
                                        end
                                        OP_LUMA:
                                        begin
                                            luma_tag_reg <= byte_reg;
                                            phase_reg    <= PH_LUMA2;
                                        end
                                        default:
                                        begin
                                            // run of byte[5:0] + 1 pixels
                                            count_reg <= byte_reg[5:0];
                                            state_reg <= S_WR;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                end

                S_WR:
                begin
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (status.done)
                    begin
                        state_reg <= S_IN;
                    end
                    else if (status.ready)
                    begin
                        if (count_reg == '0)
                        begin
                            state_reg <= S_IN;
                        end
                        else
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IN;
                end
            endcase
        end
    end

    // read at the accepted byte's low bits, write back the finished pixel at its hash
    qoi_color_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (ctl.clear),
        .rd_en   (accept),
        .rd_addr (byte_item.data_byte[SLOT_BITS-1:0]),
        .rd_data (index_pixel),
        .wr_en   (state_reg == S_WR),
        .wr_addr (slot_of(pixel_reg)),
        .wr_data (pixel_reg)
    );

    qoi_pixel_emitter u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .pixel       (pixel_reg),
        .width       (width_reg),
        .height      (height_reg),
        .status      (status),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_item  (pixel_item)
    );

endmodule

// ----- tb/tb_qoi_image_decoder.sv -----
// Self-checking testbench for the QOI chunk-stream decoder with a pixel scoreboard.
`timescale 1ns / 100ps

module tb_qoi_image_decoder;

    import qoi_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int TOTAL_ITEMS  = 310;
    // Covers a byte that makes no pixel but is still being decoded.
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // Parser position inside a multi-byte chunk
    typedef enum logic [2:0] {
        AT_TAG,
        AT_LUMA_LOW,
        AT_RED,
        AT_GREEN,
        AT_BLUE,
        AT_ALPHA
    } chunk_phase_t;

    // Decoder state shadow plus the queue of pixels still owed by the block.
    class pixel_scoreboard;
        logic [15:0]  width_reg;
        logic [15:0]  height_reg;
        pixel_t       cur_pixel;
        pixel_t       palette [64];
        chunk_phase_t phase;
        logic [7:0]   open_tag;
        int unsigned  col;
        int unsigned  row;
        bit           done;
        pixel_item_t  owed_pixels [$];
        int           mismatches;

        function new();
            width_reg  = '0;
            height_reg = '0;
            mismatches = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (palette[i])
                palette[i] = '0;
            cur_pixel = PIXEL_RESET;
            phase     = AT_TAG;
            open_tag  = '0;
            col       = 0;
            row       = 0;
            done      = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg = value;
                CFG_IMAGE_HEIGHT: height_reg = value;
                default: ;
            endcase
        endfunction

        // Store the pixel at its hash slot, then queue up to count copies,
        // stopping at the last pixel of the image.
        function void emit_run(int unsigned count);
            int unsigned slot;
            int unsigned next_col;
            int unsigned next_row;
            pixel_item_t px;
            slot = (32'(cur_pixel.red) * 3 + 32'(cur_pixel.green) * 5
                  + 32'(cur_pixel.blue) * 7 + 32'(cur_pixel.alpha) * 11) % 64;
            palette[slot] = cur_pixel;
            while (count > 0 && !done)
            begin
                px.red       = cur_pixel.red;
                px.green     = cur_pixel.green;
                px.blue      = cur_pixel.blue;
                px.alpha     = cur_pixel.alpha;
                px.column    = col[15:0];
                px.row       = row[15:0];
                px.image_end = 1'b0;
                next_col     = col + 1;
                next_row     = row;
                if (next_col >= width_reg)
                begin
                    next_col = 0;
                    next_row = row + 1;
                    if (next_row >= height_reg)
                    begin
                        done         = 1'b1;
                        px.image_end = 1'b1;
                        next_row     = 0;
                    end
                end
                col          = next_col & 32'hffff;
                row          = next_row & 32'hffff;
                px.burst_end = (count == 1) || done;
                owed_pixels.push_back(px);
                count--;
            end
        endfunction

        // Returns 1 when the byte was parsed, 0 when the block ignores it.
        function bit note_byte(byte_item_t item);
            logic [7:0]  b;
            logic [7:0]  vg;
            int unsigned run_len;
            b = item.data_byte;
            if (item.start_image)
                clear_image();
            if (done || width_reg == 0 || height_reg == 0)
                return 1'b0;

            case (phase)
                AT_LUMA_LOW:
                begin
                    vg = {2'b00, open_tag[5:0]};
                    cur_pixel.red   = cur_pixel.red + vg + {4'h0, b[7:4]} - 8'd40;
                    cur_pixel.green = cur_pixel.green + vg - 8'd32;
                    cur_pixel.blue  = cur_pixel.blue + vg + {4'h0, b[3:0]} - 8'd40;
                    phase = AT_TAG;
                    emit_run(1);
                    return 1'b1;
                end
                AT_RED:
                begin
                    cur_pixel.red = b;
                    phase = AT_GREEN;
                    return 1'b1;
                end
                AT_GREEN:
                begin
                    cur_pixel.green = b;
                    phase = AT_BLUE;
                    return 1'b1;
                end
                AT_BLUE:
                begin
                    cur_pixel.blue = b;
                    if (open_tag == TAG_RGBA)
                        phase = AT_ALPHA;
                    else
                    begin
                        phase = AT_TAG;
                        emit_run(1);
                    end
                    return 1'b1;
                end
                AT_ALPHA:
                begin
                    cur_pixel.alpha = b;
                    phase = AT_TAG;
                    emit_run(1);
                    return 1'b1;
                end
                default: ;
            endcase

            if (b == TAG_RGB || b == TAG_RGBA)
            begin
                open_tag = b;
                phase    = AT_RED;
                return 1'b1;
            end
            case (b[7:6])
                OP_INDEX:
                begin
                    cur_pixel = palette[b[5:0]];
                    emit_run(1);
                end
                OP_DIFF:
                begin
                    cur_pixel.red   = cur_pixel.red + {6'd0, b[5:4]} - 8'd2;
                    cur_pixel.green = cur_pixel.green + {6'd0, b[3:2]} - 8'd2;
                    cur_pixel.blue  = cur_pixel.blue + {6'd0, b[1:0]} - 8'd2;
                    emit_run(1);
                end
                OP_LUMA:
                begin
                    open_tag = b;
                    phase    = AT_LUMA_LOW;
                end
                default:
                begin
                    run_len = 32'(b[5:0]);
                    emit_run(run_len + 1);
                end
            endcase
            return 1'b1;
        endfunction

        function void check_pixel(pixel_item_t got);
            pixel_item_t want;
            if (owed_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: r=%h g=%h b=%h a=%h col=%0d row=%0d",
                             got.red, got.green, got.blue, got.alpha, got.column, got.row);
                return;
            end
            want = owed_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.column !== want.column || got.row !== want.row ||
                got.burst_end !== want.burst_end || got.image_end !== want.image_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("pixel mismatch: exp rgba=%h%h%h%h col=%0d row=%0d be=%b ie=%b",
                             want.red, want.green, want.blue, want.alpha, want.column,
                             want.row, want.burst_end, want.image_end);
                    $display("                got rgba=%h%h%h%h col=%0d row=%0d be=%b ie=%b",
                             got.red, got.green, got.blue, got.alpha, got.column,
                             got.row, got.burst_end, got.image_end);
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed_pixels.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]   cfg_data;
    logic                    byte_valid;
    logic                    byte_ready;
    byte_item_t              byte_item;
    logic                    pixel_valid;
    logic                    pixel_ready;
    pixel_item_t             pixel_item;

    pixel_scoreboard sb;

    int          burst_left;     // bytes left in the current sender burst
    bit          start_next;     // next byte carries start_image
    int          sent_count;     // bytes accepted by the decoder so far
    int          random_goal;    // sent_count at which random stimulus stops
    bit          hold_armed;     // lets the receiver do its long hold-off
    int unsigned cycle_count;

    qoi_image_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_item  (pixel_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Byte channel: bursts of random length separated by random gaps.
    // A zero gap merges two bursts, so long stretches run back to back.
    // Valid is never dropped while a transaction is pending.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value);
        int         gap;
        byte_item_t item;
        item.data_byte   = value;
        item.start_image = start_next;
        start_next       = 1'b0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_item  <= item;
        byte_valid <= 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        void'(sb.note_byte(item));
        sent_count++;
    endtask

    // Drop valid and wait until every owed pixel is back, then give a
    // byte that makes no pixel time to finish its decode.
    task automatic settle();
        byte_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, value);
    endtask

    // Only called with the decoder idle.
    task automatic configure(input logic [15:0] w, input logic [15:0] h,
                             input bit set_w, input bit set_h);
        if (set_w)
            write_reg(CFG_IMAGE_WIDTH, w);
        if (set_h)
            write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // One chunk with random content; a small share is noise or a chunk
    // cut short (sometimes by a start flag on the next byte).
    task automatic send_chunk();
        int kind;
        int run_len;
        kind = $urandom_range(0, 99);
        if (kind < 20)
            send_byte({OP_INDEX, 6'($urandom_range(0, 63))});
        else if (kind < 40)
            send_byte({OP_DIFF, 6'($urandom_range(0, 63))});
        else if (kind < 58)
        begin
            send_byte({OP_LUMA, 6'($urandom_range(0, 63))});
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 68)
        begin
            send_byte(TAG_RGB);
            repeat (3) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 76)
        begin
            send_byte(TAG_RGBA);
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            // mostly short runs; 62 and 63 would be the RGB/RGBA tags
            run_len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                  : $urandom_range(0, 61);
            send_byte({OP_RUN, 6'(run_len)});
        end
        else if (kind < 95)
            send_byte(8'($urandom_range(0, 255)));
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_byte(TAG_RGB);
                    send_byte(8'($urandom_range(0, 255)));
                end
                1:
                begin
                    send_byte(TAG_RGBA);
                    repeat (2) send_byte(8'($urandom_range(0, 255)));
                end
                default:
                    send_byte({OP_LUMA, 6'($urandom_range(0, 63))});
            endcase
            if ($urandom_range(0, 1) == 1)
                start_next = 1'b1;
        end
    endtask

    // One image: fresh dimensions, a start byte, chunks until the image is
    // complete or a limit is hit, then the end marker. Some images get a
    // register rewritten part way through, decoder idle, image still open.
    task automatic random_image();
        int          shape;
        int          chunks;
        bit          reshape;
        logic [15:0] w;
        logic [15:0] h;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            w = 16'($urandom_range(100, 400));
            h = 16'($urandom_range(1, 2));
        end
        else if (shape == 1)
        begin
            w = 16'd1;
            h = 16'($urandom_range(1, 20));
        end
        else if (shape == 2)
        begin
            w = 16'($urandom_range(1, 3));
            h = 16'($urandom_range(1, 3));
        end
        else
        begin
            w = 16'($urandom_range(1, 10));
            h = 16'($urandom_range(1, 8));
        end
        configure(w, h, 1'b1, 1'b1);
        start_next = 1'b1;
        reshape    = ($urandom_range(0, 4) == 0);
        chunks     = 0;
        while (!sb.done && chunks < 120 && sent_count < random_goal)
        begin
            send_chunk();
            chunks++;
            if (reshape && chunks == 4)
            begin
                settle();
                if ($urandom_range(0, 1) == 1)
                    configure(16'($urandom_range(1, 12)), 16'd0, 1'b1, 1'b0);
                else
                    configure(16'd0, 16'($urandom_range(1, 8)), 1'b0, 1'b1);
            end
        end
        // end marker: ignored once the image is complete
        repeat (7) send_byte(8'h00);
        send_byte(8'h01);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        burst_left   = 0;
        start_next   = 1'b0;
        sent_count   = 0;
        random_goal  = 0;
        hold_armed   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero dimension: registers still at reset, then each one zero
        start_next = 1'b1;
        send_byte(8'h55);
        send_byte(8'hc5);
        settle();
        configure(16'd0, 16'd3, 1'b1, 1'b1);
        start_next = 1'b1;
        send_byte(8'h00);
        settle();
        configure(16'd5, 16'd0, 1'b1, 1'b1);
        send_byte(8'h7f);
        settle();

        // 4x3 image through every chunk type, field extremes, then a run
        // that overshoots the last pixel and bytes after completion.
        // The receiver's long hold-off comes with the first pixel here,
        // while the following bytes are still being offered.
        hold_armed = 1'b1;
        configure(16'd4, 16'd3, 1'b1, 1'b1);
        start_next = 1'b1;
        send_byte({OP_INDEX, 6'd0});
        send_byte({OP_DIFF, 6'h00});
        send_byte({OP_DIFF, 6'h3f});
        send_byte({OP_LUMA, 6'h00});
        send_byte(8'h00);
        send_byte({OP_LUMA, 6'h3f});
        send_byte(8'hff);
        send_byte(TAG_RGB);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(TAG_RGBA);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h01);
        send_byte({OP_RUN, 6'd0});
        send_byte({OP_INDEX, 6'h35});
        send_byte({OP_RUN, 6'd61});
        send_byte(8'h00);
        send_byte(8'h01);
        settle();

        // Largest dimensions; start flag lands inside an open RGB chunk
        configure(16'hffff, 16'hffff, 1'b1, 1'b1);
        start_next = 1'b1;
        send_byte(TAG_RGB);
        send_byte(8'h12);
        start_next = 1'b1;
        send_byte({OP_RUN, 6'd61});
        settle();

        // One column; start flag drops a pending LUMA chunk
        configure(16'd1, 16'hffff, 1'b1, 1'b1);
        start_next = 1'b1;
        send_byte({OP_LUMA, 6'h20});
        start_next = 1'b1;
        send_byte({OP_RUN, 6'd5});
        settle();

        // Random images until the total byte count is reached
        random_goal = TOTAL_ITEMS;
        while (sent_count < random_goal)
            random_image();

        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[qoi_image_decoder] OK");
        else
            $display("[qoi_image_decoder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Pixel channel: ready follows segments of random length, each fully
    // open, coin-flip, or mostly stalled. Once armed, one long hold-off
    // backs the block up until it refuses bytes.
    // ------------------------------------------------------------------
    initial
    begin
        int seg_left;
        int mode;
        int hold_left;
        bit hold_used;
        seg_left    = 0;
        mode        = 0;
        hold_left   = 0;
        hold_used   = 1'b0;
        pixel_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pixel_valid && pixel_ready)
                sb.check_pixel(pixel_item);
            if (hold_armed && !hold_used && pixel_valid)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    0:       pixel_ready <= 1'b1;
                    1:       pixel_ready <= 1'($urandom_range(0, 1));
                    default: pixel_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[qoi_image_decoder] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/qoi_pkg.sv
sv/qoi_color_ram.sv
sv/qoi_pixel_emitter.sv
sv/qoi_image_decoder.sv
tb/tb_qoi_image_decoder.sv
